// ===== src/stdr_pkg.sv =====
// Shared types and constants for the stick-to-direction repeat block.
// No dependencies; imported by stdr_delay and stick_to_direction_repeat_core.
package stdr_pkg;

  localparam int unsigned DirW   = 4;
  localparam int unsigned ThrW   = 15;
  localparam int unsigned RateW  = 16;
  localparam int unsigned MagW   = 17;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;

  // direction bit positions
  localparam int unsigned DirLeft  = 0;
  localparam int unsigned DirRight = 1;
  localparam int unsigned DirUp    = 2;
  localparam int unsigned DirDown  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgConvertEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatPeriod  = 2'd2;

  localparam logic [ThrW-1:0] ThrReset = 15'd16384;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [TimeW-1:0]   time_ms;
    logic               has_focus;
  } in_req_t;

  typedef struct packed {
    logic [DirW-1:0] dir_down;
    logic [DirW-1:0] dir_pressed;
    logic [DirW-1:0] dir_released;
  } out_res_t;

  // request to the shared delay unit
  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [ThrW-1:0]  thr;
    logic [MagW-1:0]  mag;
  } delay_req_t;

endpackage

// ===== src/stdr_delay.sv =====
// Shared repeat-delay unit: one multiply, then a 16-step restoring divide.
// delay = floor(rate * (D - (mag - thr)) / D), D = 2 * (32768 - thr).
// Depends on stdr_pkg.
module stdr_delay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  stdr_pkg::delay_req_t          req_i,
  output logic                          done_o,
  output logic [stdr_pkg::RateW-1:0]    delay_o
);
  import stdr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_e;

  state_e              state_q;
  logic [MagW-1:0]     d_q;
  logic [MagW-1:0]     n_q;
  logic [RateW-1:0]    rate_q;
  logic [MagW-1:0]     rem_q;
  logic [RateW-1:0]    quo_q;
  logic [3:0]          cnt_q;
  logic                done_q;

  logic [MagW-1:0]     d_calc;
  logic [MagW-1:0]     n_calc;
  logic [32:0]         prod;
  logic [MagW:0]       trial;
  logic                ge;

  // press implies mag > thr and mag <= 32768, so D/2 <= n < D
  assign d_calc = 17'h10000 - {1'b0, req_i.thr, 1'b0};
  assign n_calc = MagW'({1'b0, d_calc} + {3'b0, req_i.thr} - {1'b0, req_i.mag});
  assign prod   = {17'b0, rate_q} * {16'b0, n_q};
  // quotient < rate, so the top 17 bits of the product start below D
  assign trial  = {rem_q, quo_q[RateW-1]};
  assign ge     = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            d_q     <= d_calc;
            n_q     <= n_calc;
            rate_q  <= req_i.rate;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          rem_q   <= prod[32:16];
          quo_q   <= prod[15:0];
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= ge ? MagW'(trial - {1'b0, d_q}) : trial[MagW-1:0];
          quo_q <= {quo_q[RateW-2:0], ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign delay_o = quo_q;

endmodule

// ===== src/stick_to_direction_repeat_core.sv =====
// Stick-to-direction converter with auto-repeat; top level.
// A request with no new press passes X_START, Y_START and FIN; an axis that sees a press
// also waits in X_WAIT or Y_WAIT while the shared delay unit runs (setup, multiply, 16 divide
// steps). One request at a time; the next can be taken in the same cycle as the result
// appears, later while the output stalls.
// Reset (async, active low): conversion off, threshold 16384, period 0, no deadlines.
// Depends on stdr_pkg and stdr_delay.
module stick_to_direction_repeat_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  stdr_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output stdr_pkg::out_res_t              out_res_o,
  input  logic                            cfg_we_i,
  input  logic [stdr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [stdr_pkg::CfgW-1:0]       cfg_wdata_i
);
  import stdr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_X_START, S_X_WAIT, S_Y_START, S_Y_WAIT, S_FIN
  } state_e;

  state_e             state_q;
  logic               en_q;
  logic [ThrW-1:0]    thr_q;
  logic [RateW-1:0]   rate_q;
  logic [TimeW-1:0]   dl_q [DirW];
  logic [DirW-1:0]    dlv_q;
  logic [DirW-1:0]    held_q;
  logic [DirW-1:0]    prev_q;
  logic [DirW-1:0]    press_q;
  logic               active_q;
  logic [MagW-1:0]    ax_q;
  logic [MagW-1:0]    ay_q;
  logic [TimeW-1:0]   now_q;
  logic               out_valid_q;
  out_res_t           out_res_q;

  logic               accept;
  logic               active;
  logic signed [MagW-1:0] x_ext, y_ext, thr_pos, thr_neg;
  logic [DirW-1:0]    cur;
  logic [DirW-1:0]    release_m;
  logic [DirW-1:0]    live;
  logic [DirW-1:0]    reached;
  logic [DirW-1:0]    held_fin;
  logic [TimeW-1:0]   diff [DirW];
  logic               out_free;

  logic               du_start;
  delay_req_t         du_req;
  logic               du_done;
  logic [RateW-1:0]   du_delay;
  logic [TimeW-1:0]   armed_time;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign active  = en_q && in_req_i.has_focus;
  assign x_ext   = MagW'(in_req_i.stick_x);
  assign y_ext   = MagW'(in_req_i.stick_y);
  assign thr_pos = $signed({2'b0, thr_q});
  assign thr_neg = -thr_pos;

  always_comb begin
    cur = '0;
    if (active) begin
      cur[DirLeft]  = x_ext < thr_neg;
      cur[DirRight] = x_ext > thr_pos;
      cur[DirUp]    = y_ext > thr_pos;
      cur[DirDown]  = y_ext < thr_neg;
    end
  end

  // final pass: releases disarm, then any armed deadline that has been reached drops the bit
  always_comb begin
    release_m = active_q ? (prev_q & ~held_q) : '0;
    live      = dlv_q & ~release_m;
    for (int i = 0; i < DirW; i++) begin
      diff[i]    = now_q - dl_q[i];
      reached[i] = active_q && live[i] && !diff[i][TimeW-1];
    end
    held_fin = held_q & ~reached;
  end

  assign du_start   = (state_q == S_X_START && |press_q[DirRight:DirLeft]) ||
                      (state_q == S_Y_START && |press_q[DirDown:DirUp]);
  assign du_req.rate = rate_q;
  assign du_req.thr  = thr_q;
  assign du_req.mag  = (state_q == S_X_START) ? ax_q : ay_q;
  assign armed_time  = now_q + {{(TimeW-RateW){1'b0}}, du_delay};

  stdr_delay u_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (du_start),
    .req_i   (du_req),
    .done_o  (du_done),
    .delay_o (du_delay)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      en_q        <= 1'b0;
      thr_q       <= ThrReset;
      rate_q      <= '0;
      dlv_q       <= '0;
      held_q      <= '0;
      prev_q      <= '0;
      press_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgConvertEnable: begin
            en_q  <= cfg_wdata_i[0];
            dlv_q <= '0;
          end
          CfgThreshold: begin
            thr_q <= cfg_wdata_i[ThrW-1:0];
            dlv_q <= '0;
          end
          CfgRepeatPeriod: begin
            rate_q <= cfg_wdata_i[RateW-1:0];
            dlv_q  <= '0;
          end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            prev_q   <= held_q;
            held_q   <= cur;
            press_q  <= cur & ~held_q;
            active_q <= active;
            ax_q     <= x_ext[MagW-1] ? MagW'(-x_ext) : x_ext;
            ay_q     <= y_ext[MagW-1] ? MagW'(-y_ext) : y_ext;
            now_q    <= in_req_i.time_ms;
            state_q  <= S_X_START;
          end
        end
        S_X_START: state_q <= du_start ? S_X_WAIT : S_Y_START;
        S_X_WAIT: begin
          if (du_done) begin
            for (int i = DirLeft; i <= DirRight; i++) begin
              if (press_q[i]) begin
                dl_q[i]  <= armed_time;
                dlv_q[i] <= 1'b1;
              end
            end
            state_q <= S_Y_START;
          end
        end
        S_Y_START: state_q <= du_start ? S_Y_WAIT : S_FIN;
        S_Y_WAIT: begin
          if (du_done) begin
            for (int i = DirUp; i <= DirDown; i++) begin
              if (press_q[i]) begin
                dl_q[i]  <= armed_time;
                dlv_q[i] <= 1'b1;
              end
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (active_q) begin
              dlv_q <= live & ~reached;
            end
            held_q                 <= held_fin;
            out_res_q.dir_down     <= held_fin;
            out_res_q.dir_pressed  <= held_fin & ~prev_q;
            out_res_q.dir_released <= prev_q & ~held_fin;
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== tb/tb_stick_to_direction_repeat_core.sv =====
// Testbench for stick_to_direction_repeat_core: directed and random stick frames with
// random gaps and output stalls, each result checked against a cycle-free predictor.
// Depends on stdr_pkg and the RTL of stick_to_direction_repeat_core.
module tb_stick_to_direction_repeat_core;
  timeunit 1ns;
  timeprecision 1ps;

  import stdr_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 50;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // Tracks the direction state and holds the results still to arrive.
  class dpad_scoreboard;
    logic             conv_en;
    logic [ThrW-1:0]  thr;
    logic [RateW-1:0] period;
    logic [DirW-1:0]  held;
    logic [DirW-1:0]  held_prev;
    logic [TimeW-1:0] deadline [DirW];
    logic [DirW-1:0]  armed;
    out_res_t         want_dirs [$];
    int               errors;

    function new();
      conv_en   = 1'b0;
      thr       = ThrReset;
      period    = '0;
      held      = '0;
      held_prev = '0;
      errors    = 0;
      disarm();
    endfunction

    function void disarm();
      for (int d = 0; d < DirW; d++) deadline[d] = '0;
      armed = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
      case (idx)
        CfgConvertEnable: conv_en = v[0];
        CfgThreshold:     thr = v[ThrW-1:0];
        CfgRepeatPeriod:  period = v[RateW-1:0];
        default: return;
      endcase
      disarm();
    endfunction

    // delay falls linearly from period at threshold to period/2 at full deflection
    function logic [TimeW-1:0] repeat_delay(int mag);
      longint span, num;
      span = 2 * (32768 - longint'(thr));
      num = span - (longint'(mag) - longint'(thr));
      if (num < 0) num = 0;
      return TimeW'((longint'(period) * num) / span);
    endfunction

    function out_res_t next_dirs(in_req_t r);
      int sx, sy, ax, ay, mag, t_thr;
      logic [TimeW-1:0] lag;
      out_res_t res;
      sx = int'(r.stick_x);
      sy = int'(r.stick_y);
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      t_thr = int'(thr);
      held_prev = held;
      held = '0;
      if (conv_en && r.has_focus) begin
        held[DirLeft]  = (sx < -t_thr);
        held[DirRight] = (sx > t_thr);
        held[DirUp]    = (sy > t_thr);
        held[DirDown]  = (sy < -t_thr);
        for (int d = 0; d < DirW; d++) begin
          mag = (d == DirLeft || d == DirRight) ? ax : ay;
          if (held_prev[d] && !held[d]) begin
            armed[d] = 1'b0;
            deadline[d] = '0;
          end else if (held[d] && !held_prev[d]) begin
            deadline[d] = r.time_ms + repeat_delay(mag);
            armed[d] = 1'b1;
          end
          // wrap-aware: reached when time is not behind the deadline
          lag = r.time_ms - deadline[d];
          if (armed[d] && !lag[TimeW-1]) begin
            held[d] = 1'b0;
            armed[d] = 1'b0;
            deadline[d] = '0;
          end
        end
      end
      res.dir_down     = held;
      res.dir_pressed  = held & ~held_prev;
      res.dir_released = held_prev & ~held;
      return res;
    endfunction

    function void note_request(in_req_t r);
      want_dirs.push_back(next_dirs(r));
    endfunction

    function void check_result(out_res_t got);
      out_res_t exp_res;
      if (want_dirs.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        errors++;
        return;
      end
      exp_res = want_dirs.pop_front();
      if (got.dir_down !== exp_res.dir_down) begin
        $error("dir_down: expected %h, got %h", exp_res.dir_down, got.dir_down);
        errors++;
      end
      if (got.dir_pressed !== exp_res.dir_pressed) begin
        $error("dir_pressed: expected %h, got %h", exp_res.dir_pressed, got.dir_pressed);
        errors++;
      end
      if (got.dir_released !== exp_res.dir_released) begin
        $error("dir_released: expected %h, got %h", exp_res.dir_released, got.dir_released);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  in_req_t            in_req = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  out_res_t           out_res_o;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  dpad_scoreboard sb;
  bit             calm = 1'b0;
  logic [TimeW-1:0] cur_time;
  int unsigned    idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  stick_to_direction_repeat_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // handshake monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) sb.note_request(in_req);
      if (out_valid_o && !out_stall) sb.check_result(out_res_o);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver stalls: mostly short, a few long
  initial begin
    int hold;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // axis value for a wanted direction: -1 beyond -thr, 0 inside the dead zone, 1 beyond thr (32767 if thr is 32767)
  function automatic int pick_axis(int dir, int t_thr);
    if (dir == 0) return int'($urandom_range(0, 2 * t_thr)) - t_thr;
    if (dir > 0) return (t_thr >= 32767) ? 32767 : int'($urandom_range(t_thr + 1, 32767));
    return -int'($urandom_range(t_thr + 1, 32768));
  endfunction

  task automatic push_frame(input in_req_t r);
    int gap;
    in_req   <= r;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic frame(input int x, input int y, input logic [TimeW-1:0] t, input bit f);
    in_req_t r;
    r.stick_x   = 16'(x);
    r.stick_y   = 16'(y);
    r.time_ms   = t;
    r.has_focus = f;
    push_frame(r);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] v);
    cfg_idx   <= idx;
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  // stop sending, let every outstanding result come back, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.want_dirs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input bit mid_pause);
    int run, dx, dy, k;
    logic [TimeW-1:0] step_max;
    bit f;
    in_req_t r;
    k = 0;
    while (k < n_items) begin
      run = $urandom_range(1, 12);
      dx = int'($urandom_range(0, 2)) - 1;
      dy = int'($urandom_range(0, 2)) - 1;
      f = ($urandom_range(0, 19) != 0);
      step_max = sb.period / 4 + 3;
      for (int j = 0; j < run && k < n_items; j++) begin
        if ($urandom_range(0, 99) < 12) begin
          r.stick_x   = 16'($urandom);
          r.stick_y   = 16'($urandom);
          r.time_ms   = $urandom;
          r.has_focus = 1'($urandom_range(0, 1));
          push_frame(r);
        end else begin
          if ($urandom_range(0, 49) == 0) cur_time = $urandom;
          else cur_time = cur_time + $urandom_range(0, step_max);
          frame(pick_axis(dx, sb.thr), pick_axis(dy, sb.thr), cur_time, f);
        end
        k++;
        if (mid_pause && k == n_items / 2) settle();
      end
    end
  endtask

  initial begin
    logic [ThrW-1:0]  p_thr;
    logic [RateW-1:0] p_rate;
    bit               p_en;
    sb = new();
    cur_time = $urandom;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // conversion is off after reset
    frame(32767, 0, 100, 1'b1);
    settle();
    write_reg(CfgConvertEnable, 16'hFFFF);
    write_reg(CfgThreshold, 16'hC000);
    write_reg(CfgRepeatPeriod, 16'd100);
    frame(16384, 0, 1000, 1'b1);
    frame(16385, 0, 1001, 1'b1);
    frame(32767, 0, 1050, 1'b1);
    // a write to an unused index keeps the armed deadline
    settle();
    write_reg(CfgUnused, 16'h5A5A);
    frame(32767, 0, 1100, 1'b1);
    frame(32767, 0, 1101, 1'b1);
    frame(-32768, -32768, 1110, 1'b1);
    frame(0, 32767, 1120, 1'b1);
    frame(32767, 32767, 1130, 1'b0);
    frame(-16385, -16384, 1140, 1'b1);
    frame(0, 0, 1150, 1'b1);
    // deadline lands exactly on zero after the time wraps
    frame(32767, 0, 32'hFFFF_FFCE, 1'b1);
    frame(32767, 0, 32'hFFFF_FFFF, 1'b1);
    frame(32767, 0, 32'h0000_0000, 1'b1);
    frame(32767, 0, 32'h0000_0001, 1'b1);
    frame(0, 0, 32'h0000_0002, 1'b1);
    // zero period: a press drops on the same frame
    settle();
    write_reg(CfgRepeatPeriod, 16'd0);
    frame(0, -32768, 10, 1'b1);
    frame(0, -32768, 11, 1'b1);
    settle();
    write_reg(CfgThreshold, 16'h7FFF);
    write_reg(CfgRepeatPeriod, 16'hFFFF);
    frame(32767, -32768, 20, 1'b1);
    frame(-32768, 32767, 30, 1'b1);
    settle();
    write_reg(CfgThreshold, 16'h8000);
    frame(1, -1, 40, 1'b1);
    frame(0, 0, 50, 1'b1);
    frame(-32768, 0, 32'h8000_0000, 1'b1);
    settle();

    for (int p = 0; p < 10; p++) begin
      p_en = 1'b1;
      case (p)
        0: begin p_thr = 15'd16384; p_rate = 16'd200; end
        1: begin p_thr = 15'd0; p_rate = 16'hFFFF; end
        2: begin p_thr = 15'h7FFF; p_rate = 16'd0; end
        3: begin p_en = 1'b0; p_thr = 15'($urandom); p_rate = 16'($urandom); end
        4: begin p_thr = 15'($urandom); p_rate = 16'($urandom_range(1, 500)); end
        5: begin p_thr = 15'd0; p_rate = 16'd1; end
        6: begin p_thr = 15'h7FFF; p_rate = 16'hFFFF; end
        8: begin p_thr = 15'($urandom); p_rate = 16'd40; end
        9: begin p_thr = 15'd16384; p_rate = 16'd300; end
        default: begin p_thr = 15'($urandom); p_rate = 16'($urandom); end
      endcase
      calm = (p % 4 == 2);
      write_reg(CfgConvertEnable, {15'($urandom), p_en});
      write_reg(CfgThreshold, {1'($urandom), p_thr});
      write_reg(CfgRepeatPeriod, p_rate);
      if (p % 2 == 1) write_reg(CfgUnused, 16'($urandom));
      run_phase(53, p == 5);
      settle();
    end

    if (sb.errors == 0 && sb.want_dirs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
